[rtl/core/hcrd_pkg.sv]
// Shared types and constants of the record deframer.
`default_nettype none
package hcrd_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [2:0] KIND_TIME    = 3'd0;
	localparam logic [2:0] KIND_X10     = 3'd1;
	localparam logic [2:0] KIND_NET     = 3'd2;
	localparam logic [2:0] KIND_DIN     = 3'd3;
	localparam logic [2:0] KIND_DOUT    = 3'd4;
	localparam logic [2:0] KIND_ANALOG  = 3'd5;
	localparam logic [2:0] KIND_CONSOLE = 3'd6;
	localparam logic [2:0] KIND_UNKNOWN = 3'd7;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_A      = 8'h41;

	localparam logic [7:0] TYPE_TIME    = 8'h80;
	localparam logic [7:0] TYPE_X10     = 8'h81;
	localparam logic [7:0] TYPE_DIN     = 8'h82;
	localparam logic [7:0] TYPE_DOUT    = 8'h83;
	localparam logic [7:0] TYPE_ANALOG  = 8'h84;
	localparam logic [7:0] TYPE_SKIP5   = 8'h85;
	localparam logic [7:0] TYPE_NET     = 8'h86;
	localparam logic [7:0] TYPE_SKIP2   = 8'h87;
	localparam logic [7:0] TYPE_CONSOLE = 8'h88;

	localparam logic [3:0] NIB_X10    = 4'd1;
	localparam logic [3:0] NIB_DIN    = 4'd2;
	localparam logic [3:0] NIB_DOUT   = 4'd3;
	localparam logic [3:0] NIB_ANALOG = 4'd4;
	localparam logic [3:0] NIB_NET    = 4'd6;

	localparam logic [7:0] SUB_BANK1 = 8'd8;
	localparam logic [7:0] SUB_BANK2 = 8'd96;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TYPE,
		PH_HEAD,
		PH_LOW,
		PH_HIGH,
		PH_TIME,
		PH_SKIP,
		PH_CONSOLE
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  index;
		logic [1:0]  bank;
		logic [15:0] data;
		logic        last;
	} cmd_t;

endpackage
`default_nettype wire

[rtl/core/home_controller_record_deframer_unit.sv]
// Top level of the home-controller record deframer.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    rx_byte
//   output    out        out_valid / out_ready  record_kind, item_index, item_bank,
//                                               item_value, last_of_record
//
// One byte is accepted per cycle while the request queue has room.
// A result is written into the request queue and then into the output register before it appears on the output.
// The queue of QueueDepth entries lets the parser keep taking bytes while
// the output register waits; in_ready falls only when the queue is full.
// Reset returns the parser to waiting for '$' and empties the queue.
`default_nettype none
module home_controller_record_deframer_unit #(
	parameter int unsigned QueueDepth = hcrd_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       record_kind,
	output logic [7:0]       item_index,
	output logic [1:0]       item_bank,
	output logic [15:0]      item_value,
	output logic             last_of_record
);

	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	hcrd_pkg::cmd_t push_cmd;
	hcrd_pkg::cmd_t head;

	hcrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	hcrd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	hcrd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.record_kind    (record_kind),
		.item_index     (item_index),
		.item_bank      (item_bank),
		.item_value     (item_value),
		.last_of_record (last_of_record)
	);

endmodule
`default_nettype wire

[rtl/core/hcrd_front.sv]
// Front end: byte parser that tracks record framing and issues requests.
`default_nettype none
module hcrd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          q_full,
	output logic               push,
	output hcrd_pkg::cmd_t     cmd
);

	hcrd_pkg::phase_t phase_q, phase_d;
	logic [3:0] kind_q, kind_d;
	logic [5:0] left_q, left_d;
	logic [7:0] idx_q, idx_d;
	logic [7:0] low_q, low_d;
	logic [1:0] bank_q, bank_d;
	logic       take;
	logic [1:0] sub_bank;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	always_comb begin
		if (rx_byte == hcrd_pkg::SUB_BANK1)
			sub_bank = 2'd1;
		else if (rx_byte == hcrd_pkg::SUB_BANK2)
			sub_bank = 2'd2;
		else
			sub_bank = 2'd0;
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			hcrd_pkg::PH_IDLE: begin
				if (rx_byte == hcrd_pkg::CH_DOLLAR)
					phase_d = hcrd_pkg::PH_TYPE;
			end
			hcrd_pkg::PH_TYPE: begin
				phase_d = hcrd_pkg::PH_IDLE;
				if (rx_byte[7]) begin
					case (rx_byte) inside
						hcrd_pkg::TYPE_TIME: phase_d = hcrd_pkg::PH_TIME;
						hcrd_pkg::TYPE_X10, hcrd_pkg::TYPE_DIN, hcrd_pkg::TYPE_DOUT,
						hcrd_pkg::TYPE_ANALOG, hcrd_pkg::TYPE_NET:
							phase_d = hcrd_pkg::PH_HEAD;
						hcrd_pkg::TYPE_SKIP5, hcrd_pkg::TYPE_SKIP2:
							phase_d = hcrd_pkg::PH_SKIP;
						hcrd_pkg::TYPE_CONSOLE: phase_d = hcrd_pkg::PH_CONSOLE;
						default: phase_d = hcrd_pkg::PH_IDLE;
					endcase
				end
			end
			hcrd_pkg::PH_HEAD: begin
				case (kind_q) inside
					hcrd_pkg::NIB_X10, hcrd_pkg::NIB_DIN, hcrd_pkg::NIB_DOUT,
					hcrd_pkg::NIB_ANALOG, hcrd_pkg::NIB_NET:
						phase_d = hcrd_pkg::PH_LOW;
					default: phase_d = hcrd_pkg::PH_IDLE;
				endcase
			end
			hcrd_pkg::PH_LOW: begin
				if (kind_q == hcrd_pkg::NIB_X10 || kind_q == hcrd_pkg::NIB_ANALOG)
					phase_d = hcrd_pkg::PH_HIGH;
				else
					phase_d = hcrd_pkg::PH_IDLE;
			end
			hcrd_pkg::PH_HIGH: begin
				if (kind_q == hcrd_pkg::NIB_ANALOG && left_q > 6'd1)
					phase_d = hcrd_pkg::PH_LOW;
				else
					phase_d = hcrd_pkg::PH_IDLE;
			end
			hcrd_pkg::PH_TIME: begin
				if (left_q <= 6'd1 || left_q > 6'd8)
					phase_d = hcrd_pkg::PH_IDLE;
			end
			hcrd_pkg::PH_SKIP: begin
				if (left_q <= 6'd1)
					phase_d = hcrd_pkg::PH_IDLE;
			end
			hcrd_pkg::PH_CONSOLE: begin
				if (rx_byte == 8'd0)
					phase_d = hcrd_pkg::PH_IDLE;
			end
			default: phase_d = hcrd_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		push   = 1'b0;
		cmd    = '0;
		kind_d = kind_q;
		left_d = left_q;
		idx_d  = idx_q;
		low_d  = low_q;
		bank_d = bank_q;
		unique case (phase_q)
			hcrd_pkg::PH_IDLE: begin
			end
			hcrd_pkg::PH_TYPE: begin
				kind_d = rx_byte[3:0];
				if (rx_byte[7]) begin
					case (rx_byte) inside
						hcrd_pkg::TYPE_TIME:    left_d = 6'd8;
						hcrd_pkg::TYPE_SKIP5:   left_d = 6'd5;
						hcrd_pkg::TYPE_SKIP2:   left_d = 6'd2;
						hcrd_pkg::TYPE_CONSOLE: idx_d  = 8'd0;
						hcrd_pkg::TYPE_X10, hcrd_pkg::TYPE_DIN, hcrd_pkg::TYPE_DOUT,
						hcrd_pkg::TYPE_ANALOG, hcrd_pkg::TYPE_NET: begin
						end
						default: begin
							push     = 1'b1;
							cmd.kind = hcrd_pkg::KIND_UNKNOWN;
							cmd.data = {8'd0, rx_byte};
							cmd.last = 1'b1;
						end
					endcase
				end
			end
			hcrd_pkg::PH_HEAD: begin
				case (kind_q) inside
					hcrd_pkg::NIB_X10: idx_d = rx_byte - hcrd_pkg::CH_A;
					hcrd_pkg::NIB_DIN, hcrd_pkg::NIB_DOUT, hcrd_pkg::NIB_NET:
						idx_d = rx_byte;
					hcrd_pkg::NIB_ANALOG: begin
						bank_d = sub_bank;
						left_d = (sub_bank == 2'd2) ? 6'd16 : 6'd8;
						idx_d  = 8'd0;
					end
					default: begin
					end
				endcase
			end
			hcrd_pkg::PH_LOW: begin
				case (kind_q) inside
					hcrd_pkg::NIB_X10, hcrd_pkg::NIB_ANALOG: low_d = rx_byte;
					hcrd_pkg::NIB_DIN, hcrd_pkg::NIB_DOUT: begin
						push      = 1'b1;
						cmd.kind  = (kind_q == hcrd_pkg::NIB_DIN) ?
							hcrd_pkg::KIND_DIN : hcrd_pkg::KIND_DOUT;
						cmd.index = idx_q;
						cmd.data  = {8'd0, rx_byte};
						cmd.last  = 1'b1;
					end
					hcrd_pkg::NIB_NET: begin
						push      = 1'b1;
						cmd.kind  = hcrd_pkg::KIND_NET;
						cmd.index = idx_q;
						cmd.data  = {8'd0, rx_byte};
						cmd.last  = 1'b1;
					end
					default: begin
					end
				endcase
			end
			hcrd_pkg::PH_HIGH: begin
				if (kind_q == hcrd_pkg::NIB_X10) begin
					push      = 1'b1;
					cmd.kind  = hcrd_pkg::KIND_X10;
					cmd.index = idx_q;
					cmd.data  = {rx_byte, low_q};
					cmd.last  = 1'b1;
				end else if (kind_q == hcrd_pkg::NIB_ANALOG && left_q != 6'd0) begin
					push      = 1'b1;
					cmd.kind  = hcrd_pkg::KIND_ANALOG;
					cmd.index = idx_q;
					cmd.bank  = bank_q;
					cmd.data  = {rx_byte, low_q};
					cmd.last  = (left_q == 6'd1);
					left_d    = left_q - 6'd1;
					idx_d     = idx_q + 8'd1;
				end
			end
			hcrd_pkg::PH_TIME: begin
				if (left_q != 6'd0 && left_q <= 6'd8) begin
					push      = 1'b1;
					cmd.kind  = hcrd_pkg::KIND_TIME;
					cmd.index = {4'd0, 4'd8 - left_q[3:0]};
					cmd.data  = {8'd0, rx_byte};
					cmd.last  = (left_q == 6'd1);
					left_d    = left_q - 6'd1;
				end
			end
			hcrd_pkg::PH_SKIP: begin
				if (left_q != 6'd0)
					left_d = left_q - 6'd1;
			end
			hcrd_pkg::PH_CONSOLE: begin
				push      = 1'b1;
				cmd.kind  = hcrd_pkg::KIND_CONSOLE;
				cmd.index = idx_q;
				cmd.data  = {8'd0, rx_byte};
				cmd.last  = (rx_byte == 8'd0);
				idx_d     = idx_q + 8'd1;
			end
			default: begin
			end
		endcase
		push = push && take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcrd_pkg::PH_IDLE;
			kind_q  <= '0;
			left_q  <= '0;
			idx_q   <= '0;
			low_q   <= '0;
			bank_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
			low_q   <= low_d;
			bank_q  <= bank_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/hcrd_queue.sv]
// Short request queue between parser and result stage.
`default_nettype none
module hcrd_queue #(
	parameter int unsigned Depth = hcrd_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire hcrd_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output hcrd_pkg::cmd_t      head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	hcrd_pkg::cmd_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("request popped from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

[rtl/core/hcrd_back.sv]
// Back end: turns queued requests into result fields and holds the output register.
`default_nettype none
module hcrd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire hcrd_pkg::cmd_t head,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [2:0]          record_kind,
	output logic [7:0]          item_index,
	output logic [1:0]          item_bank,
	output logic [15:0]         item_value,
	output logic                last_of_record
);

	logic        valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  index_q;
	logic [1:0]  bank_q;
	logic [15:0] value_q;
	logic        last_q;

	logic [7:0]  index_d;
	logic [15:0] value_d;
	logic [7:0]  bcd_bin;
	logic [2:0]  net_type;
	logic [1:0]  net_status;

	assign pop = !q_empty && (!valid_q || out_ready);

	always_comb begin
		bcd_bin    = ({4'd0, head.data[7:4]} << 3) + ({4'd0, head.data[7:4]} << 1)
			+ {4'd0, head.data[3:0]};
		net_type   = head.index[7] ? 3'd7 : head.index[6:4];
		net_status = (head.data[7:0] > 8'd3) ? 2'd3 : head.data[1:0];
		index_d    = head.index;
		value_d    = head.data;
		case (head.kind)
			hcrd_pkg::KIND_TIME: value_d = {8'd0, bcd_bin};
			hcrd_pkg::KIND_NET: begin
				index_d = {4'd0, head.index[3:0]};
				value_d = {11'd0, net_type, net_status};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head.kind;
			index_q <= index_d;
			bank_q  <= head.bank;
			value_q <= value_d;
			last_q  <= head.last;
		end
	end

	assign out_valid      = valid_q;
	assign record_kind    = kind_q;
	assign item_index     = index_q;
	assign item_bank      = bank_q;
	assign item_value     = value_q;
	assign last_of_record = last_q;

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == hcrd_pkg::KIND_TIME) |-> (value_q < 16'd166 && index_q < 8'd8))
		else $error("time field out of range");

endmodule
`default_nettype wire

[tb/sv/home_controller_record_deframer_unit_test.sv]
// Self-checking testbench of the home-controller record deframer: random framed byte stream.
import hcrd_pkg::*;

class deframer_scoreboard;
	phase_t      phase;
	logic [3:0]  type_nibble;
	logic [5:0]  remaining;
	logic [7:0]  index;
	logic [7:0]  low_byte;
	logic [1:0]  bank;
	cmd_t        pending_items[$];
	int          errors;

	function new();
		phase       = PH_IDLE;
		type_nibble = '0;
		remaining   = '0;
		index       = '0;
		low_byte    = '0;
		bank        = '0;
		errors      = 0;
	endfunction

	function int pending();
		return pending_items.size();
	endfunction

	function void note_request(logic [7:0] b);
		cmd_t       item;
		bit         produced;
		logic [3:0] net_type;
		logic [1:0] net_status;
		item     = '0;
		produced = 1'b0;
		case (phase)
			PH_IDLE: begin
				if (b == CH_DOLLAR)
					phase = PH_TYPE;
			end
			PH_TYPE: begin
				type_nibble = b[3:0];
				phase = PH_IDLE;
				if (b[7]) begin
					case (b)
						TYPE_TIME: begin
							remaining = 6'd8;
							phase = PH_TIME;
						end
						TYPE_X10, TYPE_DIN, TYPE_DOUT, TYPE_ANALOG, TYPE_NET:
							phase = PH_HEAD;
						TYPE_SKIP5: begin
							remaining = 6'd5;
							phase = PH_SKIP;
						end
						TYPE_SKIP2: begin
							remaining = 6'd2;
							phase = PH_SKIP;
						end
						TYPE_CONSOLE: begin
							index = '0;
							phase = PH_CONSOLE;
						end
						default: begin
							item = '{KIND_UNKNOWN, 8'd0, 2'd0, {8'd0, b}, 1'b1};
							produced = 1'b1;
						end
					endcase
				end
			end
			PH_HEAD: begin
				case (type_nibble)
					NIB_X10: begin
						index = b - CH_A;
						phase = PH_LOW;
					end
					NIB_DIN, NIB_DOUT, NIB_NET: begin
						index = b;
						phase = PH_LOW;
					end
					NIB_ANALOG: begin
						bank = (b == SUB_BANK1) ? 2'd1 : (b == SUB_BANK2) ? 2'd2 : 2'd0;
						remaining = (bank == 2'd2) ? 6'd16 : 6'd8;
						index = '0;
						phase = PH_LOW;
					end
					default: phase = PH_IDLE;
				endcase
			end
			PH_LOW: begin
				phase = PH_IDLE;
				case (type_nibble)
					NIB_X10, NIB_ANALOG: begin
						low_byte = b;
						phase = PH_HIGH;
					end
					NIB_DIN, NIB_DOUT: begin
						item = '{(type_nibble == NIB_DIN) ? KIND_DIN : KIND_DOUT, index, 2'd0,
							{8'd0, b}, 1'b1};
						produced = 1'b1;
					end
					NIB_NET: begin
						net_type = (index[7:4] > 4'd7) ? 4'd7 : index[7:4];
						net_status = (b > 8'd3) ? 2'd3 : b[1:0];
						item = '{KIND_NET, {4'd0, index[3:0]}, 2'd0,
							{11'd0, net_type[2:0], net_status}, 1'b1};
						produced = 1'b1;
					end
					default: ;
				endcase
			end
			PH_HIGH: begin
				phase = PH_IDLE;
				if (type_nibble == NIB_X10) begin
					item = '{KIND_X10, index, 2'd0, {b, low_byte}, 1'b1};
					produced = 1'b1;
				end else if (type_nibble == NIB_ANALOG && remaining != 0) begin
					item = '{KIND_ANALOG, index, bank, {b, low_byte}, remaining == 6'd1};
					produced = 1'b1;
					remaining = remaining - 6'd1;
					index = index + 8'd1;
					phase = (remaining == 0) ? PH_IDLE : PH_LOW;
				end
			end
			PH_TIME: begin
				if (remaining == 0 || remaining > 6'd8) begin
					phase = PH_IDLE;
				end else begin
					item = '{KIND_TIME, 8'd8 - {2'd0, remaining}, 2'd0,
						16'(b[7:4]) * 16'd10 + 16'(b[3:0]), remaining == 6'd1};
					produced = 1'b1;
					remaining = remaining - 6'd1;
					if (remaining == 0)
						phase = PH_IDLE;
				end
			end
			PH_SKIP: begin
				if (remaining != 0)
					remaining = remaining - 6'd1;
				if (remaining == 0)
					phase = PH_IDLE;
			end
			default: begin
				item = '{KIND_CONSOLE, index, 2'd0, {8'd0, b}, b == 8'd0};
				produced = 1'b1;
				index = index + 8'd1;
				if (b == 8'd0)
					phase = PH_IDLE;
			end
		endcase
		if (produced)
			pending_items.push_back(item);
	endfunction

	function void check_result(cmd_t got);
		cmd_t want;
		if (pending_items.size() == 0) begin
			$error("unexpected result: kind %0d index %0d value %0h",
				got.kind, got.index, got.data);
			errors++;
			return;
		end
		want = pending_items.pop_front();
		if (got.kind != want.kind) begin
			$error("record_kind: expected %0d, got %0d", want.kind, got.kind);
			errors++;
		end
		if (got.index != want.index) begin
			$error("item_index: expected %0d, got %0d", want.index, got.index);
			errors++;
		end
		if (got.bank != want.bank) begin
			$error("item_bank: expected %0d, got %0d", want.bank, got.bank);
			errors++;
		end
		if (got.data != want.data) begin
			$error("item_value: expected %0h, got %0h", want.data, got.data);
			errors++;
		end
		if (got.last != want.last) begin
			$error("last_of_record: expected %0d, got %0d", want.last, got.last);
			errors++;
		end
	endfunction
endclass

module home_controller_record_deframer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int TARGET_BYTES = 750;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  record_kind;
	logic [7:0]  item_index;
	logic [1:0]  item_bank;
	logic [15:0] item_value;
	logic        last_of_record;

	deframer_scoreboard tracker = new();
	int cycle_count = 0;
	int sent_count = 0;
	int stall_left = 0;
	bit steady = 1'b0;
	bit hold_request = 1'b0;

	home_controller_record_deframer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.record_kind(record_kind),
		.item_index(item_index),
		.item_bank(item_bank),
		.item_value(item_value),
		.last_of_record(last_of_record)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: hold off for a long stretch on request, otherwise stall at random.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 200;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(cmd_t'({record_kind, item_index, item_bank, item_value,
				last_of_record}));
	end

	task automatic send_byte(input logic [7:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= value;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(value);
		sent_count++;
	endtask

	task automatic send_frame(input logic [7:0] frame[$]);
		foreach (frame[i])
			send_byte(frame[i]);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_record(input int choice, input bit cut, input int text_len);
		logic [7:0] frame[$];
		logic [7:0] sub;
		int words;
		int n;
		frame = {CH_DOLLAR};
		case (choice)
			0: begin
				frame.push_back(TYPE_TIME);
				repeat (8)
					frame.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) :
						{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))});
			end
			1: begin
				frame.push_back(TYPE_X10);
				frame.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) :
					8'($urandom_range(CH_A, CH_A + 15)));
				frame.push_back(8'($urandom));
				frame.push_back(8'($urandom));
			end
			2, 3: begin
				frame.push_back(choice == 2 ? TYPE_DIN : TYPE_DOUT);
				frame.push_back(8'($urandom));
				frame.push_back(8'($urandom));
			end
			4: begin
				frame.push_back(TYPE_NET);
				frame.push_back(8'($urandom));
				frame.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom));
			end
			5: begin
				n = $urandom_range(0, 2);
				sub = (n == 0) ? SUB_BANK1 : (n == 1) ? SUB_BANK2 : 8'($urandom);
				words = (sub == SUB_BANK2) ? 16 : 8;
				frame.push_back(TYPE_ANALOG);
				frame.push_back(sub);
				repeat (2 * words) frame.push_back(8'($urandom));
			end
			6: begin
				n = (text_len < 0) ? $urandom_range(0, 12) : text_len;
				frame.push_back(TYPE_CONSOLE);
				repeat (n) frame.push_back(8'($urandom_range(1, 255)));
				frame.push_back(8'h00);
			end
			7: begin
				frame.push_back(TYPE_SKIP5);
				repeat (5) frame.push_back(8'($urandom));
			end
			8: begin
				frame.push_back(TYPE_SKIP2);
				repeat (2) frame.push_back(8'($urandom));
			end
			9: frame.push_back(8'($urandom_range(8'h89, 8'hFF)));
			10: frame.push_back(($urandom_range(0, 3) == 0) ? CH_DOLLAR :
				8'($urandom_range(0, 127)));
			default: begin
				frame.delete();
				repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
			end
		endcase
		if (cut && frame.size() > 2)
			frame = frame[0:$urandom_range(1, frame.size() - 2)];
		send_frame(frame);
	endtask

	initial begin
		int roll;
		bit hold_done;
		bit drain_done;
		bit wrap_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		wrap_done = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		send_frame({CH_DOLLAR, TYPE_X10, 8'h40, 8'h00, 8'hFF});
		send_frame({CH_DOLLAR, TYPE_NET, 8'hFF, 8'hFF});
		send_frame({CH_DOLLAR, 8'hFF});
		send_frame({CH_DOLLAR, CH_DOLLAR});
		send_frame({CH_DOLLAR, TYPE_CONSOLE, CH_A, 8'h00});
		send_frame({CH_DOLLAR, TYPE_SKIP2, 8'h00, 8'hFF});
		send_frame({CH_DOLLAR, 8'h7F});

		while (sent_count < TARGET_BYTES) begin
			if (!hold_done && sent_count >= 200) begin
				hold_done = 1'b1;
				hold_request = 1'b1;
				send_record(6, 1'b0, 40);
			end else if (!drain_done && sent_count >= 400) begin
				drain_done = 1'b1;
				pause_until_drained();
			end else if (!wrap_done && sent_count >= 500) begin
				wrap_done = 1'b1;
				send_record(6, 1'b0, 270);
			end else begin
				steady = (sent_count >= 300 && sent_count < 360);
				roll = $urandom_range(0, 99);
				if (roll < 85)
					send_record($urandom_range(0, 9), 1'b0, -1);
				else if (roll < 90)
					send_record(10, 1'b0, -1);
				else if (roll < 95)
					send_record(11, 1'b0, -1);
				else
					send_record($urandom_range(0, 9), 1'b1, -1);
			end
		end
		steady = 1'b0;

		pause_until_drained();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
